// ===== hdl/rrbse_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbse_pkg
// Shared types and constants of the receive ring buffer with sticky error.
// ----------------------------------------------------------------------------
package rrbse_pkg;

   localparam int DEPTH_DEFAULT = 64;   // ring slots, one always kept empty
   localparam int QUEUE_DEPTH   = 2;    // commands between front and back
   localparam int BYTE_W        = 8;
   localparam int LIMIT_W       = 6;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_ERROR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_kind_type;

   typedef enum logic [1:0] {
      STATUS_DATA  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [BYTE_W-1:0]   byte_val;
      logic [LIMIT_W-1:0]  limit;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_FETCH,
      ST_EMIT
   } back_state_type;

endpackage

// ===== hdl/receive_ring_buffer_sticky_error_top.sv =====
// ----------------------------------------------------------------------------
// receive_ring_buffer_sticky_error_top
// Byte ring buffer for received serial data with a sticky error flag.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one request per handshake. tuser carries the mode (push
//   byte, error event, read, flush); tdata carries the byte and read limit.
//   rsp channel: results of read requests only. tuser is the status, tdata
//   the byte, tlast marks the final result of a read.
//   A front stage decodes requests into a two-entry command queue; the back
//   stage owns the ring memory, pointers and error flag.
// Sequencing:
//   push, error event and flush are executed when the back stage pops them.
//   A read pops its command, then for each data byte reads the memory (read
//   port registered), then loads the result register; error and empty reads
//   give one result, loaded from the single-result state after the pop.
//   Requests queue while a read is in progress; tready drops when full.
// Reset: pointers, error flag, queue and result valid clear; ring contents
//   stay undefined until written. When the receiver stalls, hold the
//   result register and the read sequencer waits; the queue keeps filling.
// ----------------------------------------------------------------------------
module receive_ring_buffer_sticky_error_top #(
   parameter int DEPTH = rrbse_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] byte_in, [13:8] read_limit, [15:14] zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_out
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last
);
   import rrbse_pkg::*;

   logic       cmd_valid;
   logic       cmd_pop;
   cmd_type    cmd;
   status_type rsp_status;

   // decode and queue requests
   rrbse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_mode  (req_tuser),
      .req_byte  (req_tdata[7:0]),
      .req_limit (req_tdata[13:8]),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   // execute commands against the ring
   rrbse_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cmd        (cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tuser = rsp_status;

endmodule

// ===== hdl/rrbse_front.sv =====
// ----------------------------------------------------------------------------
// rrbse_front
// Accepts requests, decodes the mode into a command and queues it.
// ----------------------------------------------------------------------------
module rrbse_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [rrbse_pkg::BYTE_W-1:0]  req_byte,
   input  logic [rrbse_pkg::LIMIT_W-1:0] req_limit,
   output logic                          cmd_valid,
   input  logic                          cmd_pop,
   output rrbse_pkg::cmd_type            cmd
);
   import rrbse_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [QPTR_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   cmd_type             decoded;
   logic                push;

   always_comb begin
      decoded.kind     = cmd_kind_type'(req_mode);
      decoded.byte_val = req_byte;
      decoded.limit    = req_limit;
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (push) begin
         wr_idx_in = (wr_idx_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_idx_in = (rd_idx_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_idx_ff] <= decoded;
      end
   end

endmodule

// ===== hdl/rrbse_back.sv =====
// ----------------------------------------------------------------------------
// rrbse_back
// Executes queued commands on the byte ring and drives the result register.
// ----------------------------------------------------------------------------
module rrbse_back #(
   parameter int DEPTH = rrbse_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_pop,
   input  rrbse_pkg::cmd_type           cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rrbse_pkg::status_type        rsp_status,
   output logic [rrbse_pkg::BYTE_W-1:0] rsp_data,
   output logic                         rsp_last
);
   import rrbse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [BYTE_W-1:0]   mem_ff [DEPTH];
   logic [BYTE_W-1:0]   mem_rdata_ff;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic                error_ff, error_in;
   back_state_type      state_ff, state_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [LIMIT_W-1:0]  count_ff;
   logic                last_ff;
   status_type          single_ff;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic [BYTE_W-1:0]   rsp_data_ff;
   logic                rsp_last_ff;

   logic                out_free;
   logic                rsp_load;
   logic                is_read;
   logic                ring_empty;
   logic                ring_full;
   logic [PTR_W-1:0]    wr_next;
   logic [PTR_W-1:0]    rd_next;
   logic                do_write;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_next    = advance(wr_ptr_ff);
   assign rd_next    = advance(rd_ptr_ff);
   assign ring_empty = (rd_ptr_ff == wr_ptr_ff);
   assign ring_full  = (wr_next == rd_ptr_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign is_read    = cmd_valid && (cmd.kind == CMD_READ);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_read) begin
               if (error_ff || ring_empty || (cmd.limit == '0)) begin
                  state_in = ST_SINGLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_FETCH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = last_ff ? ST_IDLE : ST_FETCH;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
      rsp_load = ((state_ff == ST_SINGLE) || (state_ff == ST_EMIT)) && out_free;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      error_in  = error_ff;
      do_write  = 1'b0;
      if (cmd_pop) begin
         unique case (cmd.kind)
            CMD_PUSH: begin
               if (ring_full) begin
                  error_in = 1'b1;
               end else if (!error_ff) begin
                  do_write  = 1'b1;
                  wr_ptr_in = wr_next;
               end
            end
            CMD_ERROR: error_in = 1'b1;
            CMD_FLUSH: rd_ptr_in = wr_ptr_ff;
            CMD_READ: begin
               if (error_ff) begin
                  rd_ptr_in = wr_ptr_ff;
                  error_in  = 1'b0;
               end
            end
         endcase
      end else if (state_ff == ST_FETCH) begin
         rd_ptr_in = rd_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         error_ff  <= error_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ring memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= cmd.byte_val;
      end
      if (state_ff == ST_FETCH) begin
         mem_rdata_ff <= mem_ff[rd_ptr_ff];
      end
   end

   // read bookkeeping and result payload
   always_ff @(posedge clock) begin
      if (cmd_pop && (cmd.kind == CMD_READ)) begin
         limit_ff  <= cmd.limit;
         count_ff  <= '0;
         single_ff <= error_ff ? STATUS_ERROR : STATUS_EMPTY;
      end
      if (state_ff == ST_FETCH) begin
         count_ff <= count_ff + 1'b1;
         last_ff  <= (rd_next == wr_ptr_ff) ||
                     ({1'b0, count_ff} + 1'b1 == {1'b0, limit_ff});
      end
      if (rsp_load) begin
         if (state_ff == ST_SINGLE) begin
            rsp_status_ff <= single_ff;
            rsp_data_ff   <= '0;
            rsp_last_ff   <= 1'b1;
         end else begin
            rsp_status_ff <= STATUS_DATA;
            rsp_data_ff   <= mem_rdata_ff;
            rsp_last_ff   <= last_ff;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== hdl/rrbse_checker.sv =====
// ----------------------------------------------------------------------------
// rrbse_checker
// Port-level checks of the receive ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rrbse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import rrbse_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // error and empty results close their read
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_DATA) |-> rsp_tlast && (rsp_tdata == 8'd0))
      else $error("status result not last or carries data");

   // no undefined status code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_DATA) || (rsp_tuser == STATUS_EMPTY) ||
      (rsp_tuser == STATUS_ERROR))
      else $error("undefined status code");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind receive_ring_buffer_sticky_error_top rrbse_checker u_checker (.*);
